// ===== design/midiu_pkg.sv =====
// shared types, constants and helpers of the midi uart with receive fifo
`default_nettype none

package midiu_pkg;

	// receive fifo geometry
	localparam int FIFO_DEPTH = 256;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

	// item field widths
	localparam int MODE_W = 3;
	localparam int BYTE_W = 8;
	localparam int LEN_W  = 9;
	localparam int CLK_W  = 26;

	// character time arithmetic
	localparam int UNITS_W = 10;
	localparam int TICKS_W = 17;
	localparam int PROD_W  = UNITS_W + CLK_W;

	// tick divisor 500000 is 2^5 times 15625: shift out the power of two,
	// then divide by 15625 with a reciprocal multiply
	localparam int DIV_SHIFT   = 5;
	localparam int SCALED_W    = PROD_W - DIV_SHIFT;
	localparam int RECIP_W     = 32;
	localparam int RECIP_SHIFT = 45;
	localparam int RPROD_W     = SCALED_W + RECIP_W;
	// ceil(2^45 / 15625), exact floor for every 31 bit scaled product
	localparam logic [RECIP_W-1:0] RECIP_MUL = 32'd2251799814;

	localparam logic [UNITS_W-1:0] RESET_UNITS    = UNITS_W'(160);
	localparam logic [CLK_W-1:0]   CLOCK_HZ_RESET = CLK_W'(21477270);

	// item modes
	localparam logic [MODE_W-1:0] MODE_TICK     = 3'd0;
	localparam logic [MODE_W-1:0] MODE_WR_CMD   = 3'd1;
	localparam logic [MODE_W-1:0] MODE_WR_DATA  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_RD_STAT  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_RD_DATA  = 3'd4;
	localparam logic [MODE_W-1:0] MODE_LINE_BYTE = 3'd5;

	// command register fields
	localparam logic [1:0] CDIV_X1           = 2'd0;
	localparam logic [1:0] CDIV_X16          = 2'd1;
	localparam logic [1:0] CDIV_X64          = 2'd2;
	localparam logic [1:0] CDIV_MASTER_RESET = 2'd3;
	localparam int CMD_TX_IE_BIT = 5;
	localparam int CMD_RX_IE_BIT = 7;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [BYTE_W-1:0] value;
		logic [LEN_W-1:0]  chunk_length;
	} in_item_t;

	typedef struct packed {
		logic [BYTE_W-1:0] read_data;
		logic              tx_valid;
		logic [BYTE_W-1:0] tx_byte;
		logic              irq;
		logic              rx_dropped;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic mul_load;
		logic div_step;
		logic ticks_load;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic cmd_write;
	} dp_stat_t;

	// bit units of one character: frame bits times clock divider
	function automatic logic [UNITS_W-1:0] units_for(input logic [BYTE_W-1:0] cmd);
		logic [UNITS_W-1:0] bits;
		bits = UNITS_W'(10);
		case (cmd[4:2])
			3'd2, 3'd3, 3'd5, 3'd6: bits = UNITS_W'(9);
			default: bits = UNITS_W'(10);
		endcase
		case (cmd[1:0])
			CDIV_X16: units_for = bits << 4;
			CDIV_X64: units_for = bits << 6;
			default: units_for = bits;
		endcase
	endfunction

endpackage

`default_nettype wire

// ===== design/midi_uart_with_rx_fifo_top.sv =====
// top level of the 6850 style midi uart with host side receive fifo
//
// usage
// - in channel: in_valid / in_stall with an in_item of mode, value, chunk_length;
//   modes are tick, command write, data write, status read, data read and
//   received line byte
// - out channel: out_valid / out_stall, one out_item per accepted item, held in
//   an output register from the cycle after acceptance
// - cfg_we / cfg_data write clock_hz; a new value takes effect at the next
//   command write
// - throughput: one item per cycle for ticks, data writes, reads and line bytes
//   while the receiver does not stall; a command write recomputes the character
//   time in a multiply followed by a reciprocal multiply and holds in_stall
//   through the multiply, reciprocal multiply and load states
// - reset: all flags clear but transmit empty, fifo empty, and the same
//   character time calculation runs before the first item is taken
// - a stalled receiver keeps the current result; a new item is still taken in
//   the cycle the result leaves, otherwise in_stall follows out_stall
// - receive fifo of FIFO_DEPTH bytes in a registered read ram; a popped byte is
//   forwarded to data reads in the cycle after the pop
`default_nettype none

module midi_uart_with_rx_fifo_top import midiu_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	// configuration
	input  wire logic             cfg_we,
	input  wire logic [CLK_W-1:0] cfg_data,
	// item input
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire in_item_t         in_item,
	// result output
	output logic                  out_valid,
	input  wire logic             out_stall,
	output out_item_t             out_item
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// handshake and character time sequencing
	midiu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// uart state, timers, fifo and divider
	midiu_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.in_item  (in_item),
		.cmd      (cmd),
		.stat     (stat),
		.out_item (out_item)
	);

endmodule

`default_nettype wire

// ===== design/midiu_ram.sv =====
// generic single write port ram with registered read
`default_nettype none

module midiu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== design/midiu_ctrl.sv =====
// controller: handshake, output valid and character time sequencing
`default_nettype none

module midiu_ctrl import midiu_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  wire logic     out_stall,
	input  wire dp_stat_t stat,
	output dp_cmd_t       cmd
);

	localparam logic [1:0] CS_IDLE = 2'd0;
	localparam logic [1:0] CS_MUL  = 2'd1;
	localparam logic [1:0] CS_DIV  = 2'd2;
	localparam logic [1:0] CS_LOAD = 2'd3;

	logic [1:0]        state_q;
	logic [1:0]        state_d;
	logic              out_valid_q;
	logic              accept;

	assign in_stall  = (state_q != CS_IDLE) || (out_valid_q && out_stall);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd            = '0;
		cmd.accept     = accept;
		cmd.mul_load   = (state_q == CS_MUL);
		cmd.div_step   = (state_q == CS_DIV);
		cmd.ticks_load = (state_q == CS_LOAD);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			CS_IDLE: begin
				if (accept && stat.cmd_write) begin
					state_d = CS_MUL;
				end
			end
			CS_MUL: state_d = CS_DIV;
			CS_DIV: state_d = CS_LOAD;
			CS_LOAD: state_d = CS_IDLE;
			default: state_d = CS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= CS_MUL;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= accept || (out_valid_q && out_stall);
		end
	end

	// every accepted item leaves a result in the output register
	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid_q)
		else $error("accepted item produced no result");

	// a command write starts the character time calculation
	a_cmd_starts_calc: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && stat.cmd_write) |=> (state_q == CS_MUL && in_stall))
		else $error("command write did not start calculation");

	// load only follows the reciprocal multiply
	a_load_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == CS_LOAD) |-> ($past(state_q) == CS_DIV))
		else $error("load without divide");

endmodule

`default_nettype wire

// ===== design/midiu_dpath.sv =====
// datapath: uart registers, timers, receive fifo and character time divider
`default_nettype none

module midiu_dpath import midiu_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [CLK_W-1:0] cfg_data,
	input  wire in_item_t         in_item,
	input  wire dp_cmd_t          cmd,
	output dp_stat_t              stat,
	output out_item_t             out_item
);

	localparam int SUM_W = ((CNT_W > LEN_W) ? CNT_W : LEN_W) + 1;

	// architectural state
	logic [CLK_W-1:0]   clock_hz_q;
	logic [BYTE_W-1:0]  command_q;
	logic               rxrdy_q, txempty_q, ovr_q, int_q;
	logic [BYTE_W-1:0]  rx_latch_q;
	logic [BYTE_W-1:0]  tx_hold_q;
	logic               tx_busy_q;
	logic [CNT_W-1:0]   rx_count_q;
	logic [PTR_W-1:0]   rx_wptr_q;
	logic               chunk_ok_q;
	logic [TICKS_W-1:0] char_ticks_q;
	logic [TICKS_W-1:0] rx_timer_q;
	logic [TICKS_W-1:0] tx_timer_q;
	logic               tx_armed_q;
	logic [UNITS_W-1:0] units_q;
	logic               latch_pend_q;

	// divider
	logic [PROD_W-1:0]  prod_q;
	logic [RPROD_W-1:0] recip_q;

	out_item_t          out_item_q;

	// next state
	logic [BYTE_W-1:0]  n_command;
	logic               n_rxrdy, n_txempty, n_ovr, n_int;
	logic [BYTE_W-1:0]  n_tx_hold;
	logic               n_tx_busy;
	logic [CNT_W-1:0]   n_rx_count;
	logic [PTR_W-1:0]   n_rx_wptr;
	logic               n_chunk_ok;
	logic [TICKS_W-1:0] n_char_ticks;
	logic [TICKS_W-1:0] n_rx_timer;
	logic [TICKS_W-1:0] n_tx_timer;
	logic               n_tx_armed;
	logic [UNITS_W-1:0] n_units;
	logic               n_latch_pend;

	logic [BYTE_W-1:0]  rd;
	logic               txv;
	logic [BYTE_W-1:0]  txb;
	logic               dropped;
	logic               ram_we, ram_re;
	logic [PTR_W-1:0]   head_addr;
	logic [BYTE_W-1:0]  ram_rdata;
	logic [BYTE_W-1:0]  latch_now;
	logic [BYTE_W-1:0]  status_byte;
	logic [SUM_W-1:0]   chunk_sum;

	assign stat.cmd_write = (in_item.mode == MODE_WR_CMD);
	assign head_addr      = rx_wptr_q - rx_count_q[PTR_W-1:0];
	assign latch_now      = latch_pend_q ? ram_rdata : rx_latch_q;
	assign status_byte    = {int_q, 1'b0, ovr_q, 3'b000, txempty_q, rxrdy_q};
	assign chunk_sum      = SUM_W'(rx_count_q) + SUM_W'(in_item.chunk_length);

	midiu_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(FIFO_DEPTH)
	) u_rx_fifo (
		.clk   (clk),
		.we    (ram_we),
		.waddr (rx_wptr_q),
		.wdata (in_item.value),
		.re    (ram_re),
		.raddr (head_addr),
		.rdata (ram_rdata)
	);

	always_comb begin
		logic ok;
		ok           = chunk_ok_q;
		n_command    = command_q;
		n_rxrdy      = rxrdy_q;
		n_txempty    = txempty_q;
		n_ovr        = ovr_q;
		n_int        = int_q;
		n_tx_hold    = tx_hold_q;
		n_tx_busy    = tx_busy_q;
		n_rx_count   = rx_count_q;
		n_rx_wptr    = rx_wptr_q;
		n_chunk_ok   = chunk_ok_q;
		n_char_ticks = char_ticks_q;
		n_rx_timer   = rx_timer_q;
		n_tx_timer   = tx_timer_q;
		n_tx_armed   = tx_armed_q;
		n_units      = units_q;
		n_latch_pend = 1'b0;
		rd           = '0;
		txv          = 1'b0;
		txb          = '0;
		dropped      = 1'b0;
		ram_we       = 1'b0;
		ram_re       = 1'b0;

		if (cmd.ticks_load) begin
			n_char_ticks = recip_q[RECIP_SHIFT +: TICKS_W];
			n_rx_timer   = recip_q[RECIP_SHIFT +: TICKS_W];
		end

		if (cmd.accept) begin
			case (in_item.mode)
				MODE_TICK: begin
					// receive timer first
					if (rx_timer_q > TICKS_W'(1)) begin
						n_rx_timer = rx_timer_q - TICKS_W'(1);
					end else begin
						if (rxrdy_q) begin
							n_ovr = 1'b1;
						end else if (rx_count_q != '0) begin
							ram_re       = 1'b1;
							n_latch_pend = 1'b1;
							n_rx_count   = rx_count_q - CNT_W'(1);
							n_rxrdy      = 1'b1;
							if (command_q[CMD_RX_IE_BIT]) begin
								n_int = 1'b1;
							end
						end
						n_rx_timer = char_ticks_q;
					end
					// then transmit timer
					if (tx_armed_q) begin
						if (tx_timer_q > TICKS_W'(1)) begin
							n_tx_timer = tx_timer_q - TICKS_W'(1);
						end else begin
							n_tx_armed = 1'b0;
							n_tx_timer = '0;
							if (txempty_q) begin
								n_tx_busy = 1'b0;
							end else begin
								txv        = 1'b1;
								txb        = tx_hold_q;
								n_tx_timer = char_ticks_q;
								n_tx_armed = 1'b1;
								n_txempty  = 1'b1;
								if (command_q[CMD_TX_IE_BIT]) begin
									n_int = 1'b1;
								end
							end
						end
					end
				end
				MODE_WR_CMD: begin
					n_units = units_for(in_item.value);
					if (in_item.value[1:0] == CDIV_MASTER_RESET) begin
						n_command  = '0;
						n_rxrdy    = 1'b0;
						n_txempty  = 1'b1;
						n_ovr      = 1'b0;
						n_int      = 1'b0;
						n_tx_busy  = 1'b0;
						n_rx_count = '0;
						n_tx_timer = '0;
						n_tx_armed = 1'b0;
					end else begin
						n_command = in_item.value;
					end
				end
				MODE_WR_DATA: begin
					if (txempty_q) begin
						if (!tx_busy_q) begin
							txv        = 1'b1;
							txb        = in_item.value;
							n_tx_timer = char_ticks_q;
							n_tx_armed = 1'b1;
							n_tx_busy  = 1'b1;
						end else begin
							n_txempty = 1'b0;
							n_tx_hold = in_item.value;
						end
					end
				end
				MODE_RD_STAT: begin
					rd    = status_byte;
					n_int = 1'b0;
				end
				MODE_RD_DATA: begin
					rd      = latch_now;
					n_rxrdy = 1'b0;
					n_ovr   = 1'b0;
				end
				MODE_LINE_BYTE: begin
					if (in_item.chunk_length != '0) begin
						ok         = (chunk_sum < SUM_W'(FIFO_DEPTH));
						n_chunk_ok = ok;
					end
					if (ok && (rx_count_q < CNT_W'(FIFO_DEPTH))) begin
						ram_we     = 1'b1;
						n_rx_wptr  = rx_wptr_q + PTR_W'(1);
						n_rx_count = rx_count_q + CNT_W'(1);
					end else begin
						dropped = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_hz_q   <= CLOCK_HZ_RESET;
			command_q    <= '0;
			rxrdy_q      <= 1'b0;
			txempty_q    <= 1'b1;
			ovr_q        <= 1'b0;
			int_q        <= 1'b0;
			rx_latch_q   <= '0;
			tx_hold_q    <= '0;
			tx_busy_q    <= 1'b0;
			rx_count_q   <= '0;
			rx_wptr_q    <= '0;
			chunk_ok_q   <= 1'b0;
			char_ticks_q <= '0;
			rx_timer_q   <= '0;
			tx_timer_q   <= '0;
			tx_armed_q   <= 1'b0;
			units_q      <= RESET_UNITS;
			latch_pend_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				clock_hz_q <= cfg_data;
			end
			command_q    <= n_command;
			rxrdy_q      <= n_rxrdy;
			txempty_q    <= n_txempty;
			ovr_q        <= n_ovr;
			int_q        <= n_int;
			rx_latch_q   <= latch_now;
			tx_hold_q    <= n_tx_hold;
			tx_busy_q    <= n_tx_busy;
			rx_count_q   <= n_rx_count;
			rx_wptr_q    <= n_rx_wptr;
			chunk_ok_q   <= n_chunk_ok;
			char_ticks_q <= n_char_ticks;
			rx_timer_q   <= n_rx_timer;
			tx_timer_q   <= n_tx_timer;
			tx_armed_q   <= n_tx_armed;
			units_q      <= n_units;
			latch_pend_q <= n_latch_pend;
		end
	end

	// bit units times clock rate, then divide by the tick divisor:
	// drop its power of two and multiply by the reciprocal of the odd part
	always_ff @(posedge clk) begin
		if (cmd.mul_load) begin
			prod_q <= PROD_W'(units_q) * PROD_W'(clock_hz_q);
		end else if (cmd.div_step) begin
			recip_q <= RPROD_W'(prod_q[PROD_W-1:DIV_SHIFT]) * RPROD_W'(RECIP_MUL);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			out_item_q.read_data  <= rd;
			out_item_q.tx_valid   <= txv;
			out_item_q.tx_byte    <= txb;
			out_item_q.irq        <= n_int;
			out_item_q.rx_dropped <= dropped;
		end
	end

	assign out_item = out_item_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rx_count_q <= CNT_W'(FIFO_DEPTH))
		else $error("fifo count beyond depth");

	// the latch load pending after a fifo pop is never still pending in the following cycle
	a_pend_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		latch_pend_q |=> !latch_pend_q)
		else $error("latch load pending too long");

	a_pend_ready: assert property (@(posedge clk) disable iff (!arst_n)
		latch_pend_q |-> rxrdy_q)
		else $error("latch loaded without ready flag");

endmodule

`default_nettype wire
